/* rtl/stl_pkg.sv */
// Package: shared types and constants for the script token lexer.
`timescale 1ns / 1ps
package stl_pkg;
   localparam int POSITION_BITS_DEF = 32;
   localparam int KEYWORD_CHARS_DEF = 8;

   typedef enum logic [3:0] {
      M_IDLE, M_INT, M_POINT, M_FRAC, M_STR, M_ESC, M_WORD,
      M_EQ, M_SLASH, M_GT, M_LT, M_BANG, M_NEWRUN
   } mode_type;

   localparam logic [5:0] K_INT = 6'd0, K_FLT = 6'd1, K_ID = 6'd2, K_STR = 6'd3,
      K_LPAR = 6'd4, K_RPAR = 6'd5, K_LBRC = 6'd6, K_RBRC = 6'd7, K_LSQB = 6'd8,
      K_RSQB = 6'd9, K_SEP = 6'd10, K_NEW = 6'd11, K_EOF = 6'd12, K_SET = 6'd13,
      K_ADD = 6'd14, K_SUB = 6'd15, K_MUL = 6'd16, K_DIV = 6'd17, K_FDIV = 6'd18,
      K_MOD = 6'd19, K_POW = 6'd20, K_EQU = 6'd21, K_NEQ = 6'd22, K_GTR = 6'd23,
      K_GEQ = 6'd24, K_LSS = 6'd25, K_LEQ = 6'd26, K_NONE = 6'd63;

   localparam logic [5:0] K_IF = 6'd30, K_ELIF = 6'd31, K_ELSE = 6'd32, K_FOR = 6'd33,
      K_FROM = 6'd34, K_TO = 6'd35, K_WHILE = 6'd36, K_DEF = 6'd37, K_RETURN = 6'd38,
      K_BREAK = 6'd39, K_CONTINUE = 6'd40;

   localparam logic [2:0] E_NONE = 3'd0, E_UNKNOWN = 3'd1, E_NOPOINT = 3'd2,
      E_UNTERM = 3'd3, E_ESCAPE = 3'd4;

   localparam logic [30:0] INT_MAX31 = 31'h7FFFFFFF;

   // one token as handed from front to back
   typedef struct packed {
      logic [5:0]  kind;
      logic [31:0] start;
      logic [31:0] stop;
      logic [30:0] value;
      logic [2:0]  err;
      logic        last;
   } tok_type;

   function automatic logic [5:0] single_kind(input logic [20:0] c);
      case (c)
         21'h28: return K_LPAR;
         21'h29: return K_RPAR;
         21'h7B: return K_LBRC;
         21'h7D: return K_RBRC;
         21'h5B: return K_LSQB;
         21'h5D: return K_RSQB;
         21'h2C: return K_SEP;
         21'h2B: return K_ADD;
         21'h2D: return K_SUB;
         21'h2A: return K_MUL;
         21'h25: return K_MOD;
         21'h5E: return K_POW;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic is_digit(input logic [20:0] c);
      return c >= 21'd48 && c <= 21'd57;
   endfunction

   function automatic logic is_alpha(input logic [20:0] c);
      return (c >= 21'h61 && c <= 21'h7A) || (c >= 21'h41 && c <= 21'h5A) || c == 21'h5F;
   endfunction

   // keyword lookup on 8 packed 7-bit chars, length lw
   function automatic logic [5:0] kw_kind(input logic [55:0] w, input logic [3:0] lw);
      logic [5:0] k;
      k = K_ID;
      case (lw)
         4'd2: begin
            if (w[13:0] == {7'h66, 7'h69}) k = K_IF;
            else if (w[13:0] == {7'h6F, 7'h74}) k = K_TO;
         end
         4'd3: begin
            if (w[20:0] == {7'h72, 7'h6F, 7'h66}) k = K_FOR;
            else if (w[20:0] == {7'h66, 7'h65, 7'h64}) k = K_DEF;
         end
         4'd4: begin
            if (w[27:0] == {7'h66, 7'h69, 7'h6C, 7'h65}) k = K_ELIF;
            else if (w[27:0] == {7'h65, 7'h73, 7'h6C, 7'h65}) k = K_ELSE;
            else if (w[27:0] == {7'h6D, 7'h6F, 7'h72, 7'h66}) k = K_FROM;
         end
         4'd5: begin
            if (w[34:0] == {7'h65, 7'h6C, 7'h69, 7'h68, 7'h77}) k = K_WHILE;
            else if (w[34:0] == {7'h6B, 7'h61, 7'h65, 7'h72, 7'h62}) k = K_BREAK;
         end
         4'd6: begin
            if (w[41:0] == {7'h6E, 7'h72, 7'h75, 7'h74, 7'h65, 7'h72}) k = K_RETURN;
         end
         4'd8: begin
            if (w == {7'h65, 7'h75, 7'h6E, 7'h69, 7'h74, 7'h6E, 7'h6F, 7'h63}) k = K_CONTINUE;
         end
         default: k = K_ID;
      endcase
      return k;
   endfunction
endpackage

/* rtl/stl_front.sv */
// Front end: scanner state machine, classifies characters and forms up to two tokens.
`timescale 1ns / 1ps
module stl_front #(
   parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
   parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [20:0]      char_code,
   input  logic             take,
   output logic [1:0]       tok_cnt,
   output stl_pkg::tok_type tok0,
   output stl_pkg::tok_type tok1
);
   localparam int LW = $clog2(KEYWORD_CHARS + 2);
   localparam int IW = $clog2(KEYWORD_CHARS);

   stl_pkg::mode_type mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pst_ff, pst_in;
   logic [30:0] acc_ff, acc_in;
   logic [LW-1:0] wlen_ff, wlen_in;
   logic halt_ff, halt_in;
   logic [6:0] wch_ff [KEYWORD_CHARS];
   logic wr_en;
   logic [IW-1:0] wr_idx;
   logic [6:0] wr_val;

   logic [55:0] wpack;
   logic [3:0] wlen4;
   logic [POSITION_BITS-1:0] pos1, ps1;
   logic [34:0] mul10;

   always_comb begin
      for (int i = 0; i < 8; i++) wpack[i*7 +: 7] = wch_ff[i];
   end
   assign wlen4 = (wlen_ff > LW'(KEYWORD_CHARS)) ? 4'd15 :
      (KEYWORD_CHARS > 8 && wlen_ff > LW'(8)) ? 4'd15 : 4'(wlen_ff);
   assign pos1 = pos_ff + 1'b1;
   assign ps1 = pst_ff + 1'b1;
   assign mul10 = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + 35'(char_code[3:0]);

   function automatic stl_pkg::tok_type mk(input logic [5:0] k,
      input logic [POSITION_BITS-1:0] s, input logic [POSITION_BITS-1:0] e,
      input logic [30:0] v, input logic [2:0] er);
      stl_pkg::tok_type t;
      t.kind = k;
      t.start = 32'(s);
      t.stop = 32'(e);
      t.value = v;
      t.err = er;
      t.last = 1'b0;
      return t;
   endfunction

   always_comb begin
      logic fr;
      logic [5:0] sk;
      stl_pkg::tok_type t;
      logic hold;
      logic pair;
      logic [5:0] k2, k1;
      fr = 1'b0;
      hold = 1'b0;
      t = '0;
      pair = 1'b0;
      k2 = stl_pkg::K_EQU;
      k1 = stl_pkg::K_SET;
      mode_in = mode_ff;
      pst_in = pst_ff;
      acc_in = acc_ff;
      wlen_in = wlen_ff;
      halt_in = halt_ff;
      tok_cnt = 2'd0;
      tok0 = '0;
      tok1 = '0;
      wr_en = 1'b0;
      wr_idx = '0;
      wr_val = char_code[6:0];
      sk = stl_pkg::single_kind(char_code);
      case (mode_ff)
         stl_pkg::M_INT: begin
            if (stl_pkg::is_digit(char_code))
               acc_in = (mul10 > 35'(stl_pkg::INT_MAX31)) ? stl_pkg::INT_MAX31 : mul10[30:0];
            else if (char_code == 21'h2E) mode_in = stl_pkg::M_POINT;
            else begin
               tok0 = mk(stl_pkg::K_INT, pst_ff, pos_ff, acc_ff, stl_pkg::E_NONE);
               tok_cnt = 2'd1;
               fr = 1'b1;
            end
         end
         stl_pkg::M_POINT: begin
            if (stl_pkg::is_digit(char_code)) mode_in = stl_pkg::M_FRAC;
            else begin
               tok0 = mk('0, pst_ff, pos1, '0, stl_pkg::E_NOPOINT);
               tok_cnt = 2'd1;
               halt_in = 1'b1;
               mode_in = stl_pkg::M_IDLE;
            end
         end
         stl_pkg::M_FRAC: begin
            if (!stl_pkg::is_digit(char_code)) begin
               tok0 = mk(stl_pkg::K_FLT, pst_ff, pos_ff, '0, stl_pkg::E_NONE);
               tok_cnt = 2'd1;
               fr = 1'b1;
            end
         end
         stl_pkg::M_STR: begin
            if (char_code == '0) begin
               tok0 = mk('0, pst_ff, pos1, '0, stl_pkg::E_UNTERM);
               tok_cnt = 2'd1;
               halt_in = 1'b1;
               mode_in = stl_pkg::M_IDLE;
            end else if (char_code == 21'h5C) mode_in = stl_pkg::M_ESC;
            else if (char_code == 21'h22) begin
               tok0 = mk(stl_pkg::K_STR, pst_ff, pos1, '0, stl_pkg::E_NONE);
               tok_cnt = 2'd1;
               mode_in = stl_pkg::M_IDLE;
            end
         end
         stl_pkg::M_ESC: begin
            if (char_code == '0) begin
               tok0 = mk('0, pst_ff, pos1, '0, stl_pkg::E_UNTERM);
               tok_cnt = 2'd1;
               halt_in = 1'b1;
               mode_in = stl_pkg::M_IDLE;
            end else if (char_code == 21'h5C || char_code == 21'h22 || char_code == 21'h6E
                         || char_code == 21'h0D || char_code == 21'h0A)
               mode_in = stl_pkg::M_STR;
            else begin
               tok0 = mk('0, pst_ff, pos1, '0, stl_pkg::E_ESCAPE);
               tok_cnt = 2'd1;
               halt_in = 1'b1;
               mode_in = stl_pkg::M_IDLE;
            end
         end
         stl_pkg::M_WORD: begin
            if (stl_pkg::is_alpha(char_code) || stl_pkg::is_digit(char_code)) begin
               if (wlen_ff < LW'(KEYWORD_CHARS)) begin
                  wr_en = 1'b1;
                  wr_idx = IW'(wlen_ff);
               end
               if (wlen_ff <= LW'(KEYWORD_CHARS)) wlen_in = wlen_ff + 1'b1;
            end else begin
               tok0 = mk(stl_pkg::kw_kind(wpack, wlen4), pst_ff, pos_ff, '0, stl_pkg::E_NONE);
               tok_cnt = 2'd1;
               fr = 1'b1;
            end
         end
         stl_pkg::M_EQ, stl_pkg::M_SLASH, stl_pkg::M_GT, stl_pkg::M_LT: begin
            pair = (mode_ff == stl_pkg::M_SLASH) ? (char_code == 21'h2F) : (char_code == 21'h3D);
            case (mode_ff)
               stl_pkg::M_EQ:    begin k2 = stl_pkg::K_EQU;  k1 = stl_pkg::K_SET; end
               stl_pkg::M_SLASH: begin k2 = stl_pkg::K_FDIV; k1 = stl_pkg::K_DIV; end
               stl_pkg::M_GT:    begin k2 = stl_pkg::K_GEQ;  k1 = stl_pkg::K_GTR; end
               default:          begin k2 = stl_pkg::K_LEQ;  k1 = stl_pkg::K_LSS; end
            endcase
            mode_in = stl_pkg::M_IDLE;
            tok_cnt = 2'd1;
            if (pair) tok0 = mk(k2, pst_ff, pos1, '0, stl_pkg::E_NONE);
            else begin
               tok0 = mk(k1, pst_ff, ps1, '0, stl_pkg::E_NONE);
               fr = 1'b1;
            end
         end
         stl_pkg::M_BANG: begin
            tok_cnt = 2'd1;
            mode_in = stl_pkg::M_IDLE;
            if (char_code == 21'h3D) tok0 = mk(stl_pkg::K_NEQ, pst_ff, pos1, '0, stl_pkg::E_NONE);
            else begin
               tok0 = mk('0, pst_ff, ps1, '0, stl_pkg::E_UNKNOWN);
               halt_in = 1'b1;
            end
         end
         stl_pkg::M_NEWRUN: begin
            if (!(char_code == 21'h20 || char_code == 21'h09 || char_code == 21'h0D ||
                  char_code == 21'h0A || char_code == 21'h3B)) begin
               tok0 = mk(stl_pkg::K_NEW, pst_ff, pos_ff, '0, stl_pkg::E_NONE);
               tok_cnt = 2'd1;
               fr = 1'b1;
            end
         end
         default: fr = 1'b1;
      endcase

      if (fr) begin
         t = '0;
         t.start = 32'(pos_ff);
         t.stop = 32'(pos1);
         pst_in = pos_ff;
         mode_in = stl_pkg::M_IDLE;
         if (char_code == '0) begin
            t.kind = stl_pkg::K_EOF;
            t.stop = 32'(pos_ff);
            hold = 1'b1;
         end else if (stl_pkg::is_digit(char_code)) begin
            mode_in = stl_pkg::M_INT;
            acc_in = {27'd0, char_code[3:0]};
         end else if (char_code == 21'h22) mode_in = stl_pkg::M_STR;
         else if (stl_pkg::is_alpha(char_code)) begin
            mode_in = stl_pkg::M_WORD;
            wlen_in = LW'(1);
            wr_en = 1'b1;
            wr_idx = '0;
         end else if (sk != stl_pkg::K_NONE) t.kind = sk;
         else begin
            case (char_code)
               21'h3D: mode_in = stl_pkg::M_EQ;
               21'h2F: mode_in = stl_pkg::M_SLASH;
               21'h3E: mode_in = stl_pkg::M_GT;
               21'h3C: mode_in = stl_pkg::M_LT;
               21'h21: mode_in = stl_pkg::M_BANG;
               21'h20, 21'h09: mode_in = stl_pkg::M_IDLE;
               21'h0D, 21'h0A, 21'h3B: mode_in = stl_pkg::M_NEWRUN;
               default: begin
                  t.err = stl_pkg::E_UNKNOWN;
                  halt_in = 1'b1;
               end
            endcase
         end
         if (char_code == '0 || sk != stl_pkg::K_NONE || t.err != stl_pkg::E_NONE) begin
            if (tok_cnt == 2'd0) tok0 = t;
            else tok1 = t;
            tok_cnt = tok_cnt + 2'd1;
         end
      end
      if (tok_cnt == 2'd1) tok0.last = 1'b1;
      if (tok_cnt == 2'd2) tok1.last = 1'b1;
      pos_in = (char_code == '0 && fr) ? '0 : pos1;
      if (hold && char_code == '0) pos_in = '0;
      if (halt_ff) begin
         tok_cnt = 2'd0;
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stl_pkg::M_IDLE;
         pos_ff <= '0;
         pst_ff <= '0;
         acc_ff <= '0;
         wlen_ff <= '0;
         halt_ff <= 1'b0;
      end else if (take && !halt_ff) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         pst_ff <= pst_in;
         acc_ff <= acc_in;
         wlen_ff <= wlen_in;
         halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && wr_en) wch_ff[wr_idx] <= wr_val;
   end
endmodule

/* rtl/stl_back.sv */
// Back end: token queue and output stage, delivers one word per cycle while rsp_ready is high.
`timescale 1ns / 1ps
module stl_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  stl_pkg::tok_type push0,
   input  stl_pkg::tok_type push1,
   output logic             space_ok,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stl_pkg::tok_type head
);
   localparam int DEPTH = 4;
   stl_pkg::tok_type q_ff [DEPTH];
   logic [1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic pop;

   assign rsp_valid = cnt_ff != 3'd0;
   assign head = q_ff[rd_ff];
   assign pop = rsp_valid && rsp_ready;
   assign space_ok = cnt_ff <= 3'd2;
   assign rd_in = rd_ff + 2'(pop);
   assign wr_in = wr_ff + push_cnt;
   assign cnt_in = cnt_ff + 3'(push_cnt) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) q_ff[wr_ff] <= push0;
      if (push_cnt == 2'd2) q_ff[wr_ff + 2'd1] <= push1;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'(DEPTH))
      else $error("queue overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !space_ok |-> push_cnt == 2'd0) else $error("push without space");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      pop && push_cnt == 2'd0 |=> cnt_ff == $past(cnt_ff) - 3'd1) else $error("count slip");
endmodule

/* rtl/script_token_lexer_core.sv */
// Top level of the script token lexer.
`timescale 1ns / 1ps
// Streaming lexer: one character per req word, one token per rsp word. A character is
// accepted every cycle while the four-entry token queue has room for two tokens, so input
// stalls only while more than two tokens wait on rsp; a closing character may queue two
// tokens, drained at one per cycle while rsp_ready is high. A token is offered on rsp
// behind those queued ahead of it, from the cycle after its closing character is accepted
// at the earliest. After an error token the block swallows input silently until reset.
module script_token_lexer_core #(
   parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF,
   parameter int KEYWORD_CHARS = stl_pkg::KEYWORD_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [20:0] req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_token_kind,
   output logic [31:0] rsp_token_start,
   output logic [31:0] rsp_token_end,
   output logic [30:0] rsp_int_value,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_run
);
   logic [1:0] cnt;
   logic take, space_ok;
   stl_pkg::tok_type t0, t1, head;

   assign req_ready = space_ok;
   assign take = req_valid && space_ok;

   stl_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
      .clock(clock), .reset(reset), .char_code(req_char_code), .take(take),
      .tok_cnt(cnt), .tok0(t0), .tok1(t1));

   stl_back u_back (
      .clock(clock), .reset(reset), .push_cnt(take ? cnt : 2'd0), .push0(t0), .push1(t1),
      .space_ok(space_ok), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .head(head));

   assign rsp_token_kind = head.kind;
   assign rsp_token_start = head.start;
   assign rsp_token_end = head.stop;
   assign rsp_int_value = head.value;
   assign rsp_error_code = head.err;
   assign rsp_last_of_run = head.last;
endmodule

/* tb/sv/script_token_lexer_core_tb.sv */
// Testbench for script_token_lexer_core: directed and random text, checked against a predictor.
`timescale 1ns / 1ps
module script_token_lexer_core_tb;
   import stl_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_TOKENS  = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [20:0] req_char_code;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [5:0]  rsp_token_kind;
   logic [31:0] rsp_token_start;
   logic [31:0] rsp_token_end;
   logic [30:0] rsp_int_value;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_of_run;

   script_token_lexer_core u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   mode_type    lex_mode;
   logic [31:0] lex_pos;
   logic [31:0] tok_start;
   logic [30:0] int_acc;
   logic [6:0]  word_buf [0:7];
   int          word_len;
   bit          lex_halted;
   int          step_tokens;
   tok_type     token_q [$];

   bit          idle_on;
   bit          stall_on;
   int          stall_left;
   int          fail_count;
   int          quiet_cycles;

   string       kw_text [11] = '{"if", "elif", "else", "for", "from", "to", "while", "def",
                                 "return", "break", "continue"};
   logic [5:0]  kw_code [11] = '{K_IF, K_ELIF, K_ELSE, K_FOR, K_FROM, K_TO, K_WHILE,
                                 K_DEF, K_RETURN, K_BREAK, K_CONTINUE};

   function automatic bit digit_char(logic [20:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter_char(logic [20:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit blank_char(logic [20:0] c);
      return c == " " || c == 9 || c == 13 || c == 10 || c == ";";
   endfunction

   function automatic logic [5:0] punct_kind(logic [20:0] c);
      case (c)
         "(": return K_LPAR;
         ")": return K_RPAR;
         "{": return K_LBRC;
         "}": return K_RBRC;
         "[": return K_LSQB;
         "]": return K_RSQB;
         ",": return K_SEP;
         "+": return K_ADD;
         "-": return K_SUB;
         "*": return K_MUL;
         "%": return K_MOD;
         "^": return K_POW;
         default: return K_NONE;
      endcase
   endfunction

   function void push_token(logic [5:0] kind, logic [31:0] start, logic [31:0] stop,
                             logic [30:0] value, logic [2:0] err);
      tok_type t;
      t.kind = kind;
      t.start = start;
      t.stop = stop;
      t.value = value;
      t.err = err;
      t.last = 1'b0;
      token_q.push_back(t);
      step_tokens++;
   endfunction

   function void raise_error(logic [2:0] err, logic [31:0] start, logic [31:0] p);
      push_token(K_INT, start, p + 1, '0, err);
      lex_halted = 1'b1;
      lex_mode = M_IDLE;
   endfunction

   function void word_push(logic [20:0] c);
      if (word_len < 8) word_buf[word_len] = c[6:0];
      if (word_len <= 8) word_len++;
   endfunction

   function logic [5:0] word_token_kind();
      bit  hit;
      byte ch;
      if (word_len > 8) return K_ID;
      for (int i = 0; i < 11; i++) begin
         if (kw_text[i].len() != word_len) continue;
         hit = 1'b1;
         for (int j = 0; j < word_len; j++) begin
            ch = kw_text[i][j];
            if (word_buf[j] != ch[6:0]) hit = 1'b0;
         end
         if (hit) return kw_code[i];
      end
      return K_ID;
   endfunction

   // scan with nothing pending; returns 1 when the position must hold
   function bit scan_fresh(logic [20:0] c, logic [31:0] p);
      logic [5:0] k;
      tok_start = p;
      if (c == 0) begin
         push_token(K_EOF, p, p, '0, E_NONE);
         lex_pos = '0;
         return 1'b1;
      end
      if (digit_char(c)) begin
         lex_mode = M_INT;
         int_acc = 31'(c - 21'd48);
         return 1'b0;
      end
      if (c == "\"") begin
         lex_mode = M_STR;
         return 1'b0;
      end
      if (letter_char(c)) begin
         lex_mode = M_WORD;
         word_len = 0;
         word_push(c);
         return 1'b0;
      end
      k = punct_kind(c);
      if (k != K_NONE) begin
         push_token(k, p, p + 1, '0, E_NONE);
         return 1'b0;
      end
      case (c)
         "=": lex_mode = M_EQ;
         "/": lex_mode = M_SLASH;
         ">": lex_mode = M_GT;
         "<": lex_mode = M_LT;
         "!": lex_mode = M_BANG;
         " ", 9: ;
         13, 10, ";": lex_mode = M_NEWRUN;
         default: raise_error(E_UNKNOWN, p, p);
      endcase
      return 1'b0;
   endfunction

   function bit scan_pair(logic [20:0] c, logic [31:0] p, logic [20:0] second,
                          logic [5:0] two, logic [5:0] one);
      lex_mode = M_IDLE;
      if (c == second) begin
         push_token(two, tok_start, p + 1, '0, E_NONE);
         return 1'b0;
      end
      push_token(one, tok_start, tok_start + 1, '0, E_NONE);
      return scan_fresh(c, p);
   endfunction

   function void lex_char(logic [20:0] c);
      logic [31:0] p;
      bit          hold;
      longint      acc;
      if (lex_halted) return;
      p = lex_pos;
      hold = 1'b0;
      step_tokens = 0;
      case (lex_mode)
         M_INT:
            if (digit_char(c)) begin
               acc = longint'(int_acc) * 10 + longint'(c - 21'd48);
               int_acc = (acc > longint'(INT_MAX31)) ? INT_MAX31 : acc[30:0];
            end else if (c == ".") begin
               lex_mode = M_POINT;
            end else begin
               push_token(K_INT, tok_start, p, int_acc, E_NONE);
               lex_mode = M_IDLE;
               hold = scan_fresh(c, p);
            end
         M_POINT:
            if (digit_char(c)) lex_mode = M_FRAC;
            else raise_error(E_NOPOINT, tok_start, p);
         M_FRAC:
            if (!digit_char(c)) begin
               push_token(K_FLT, tok_start, p, '0, E_NONE);
               lex_mode = M_IDLE;
               hold = scan_fresh(c, p);
            end
         M_STR:
            if (c == 0) raise_error(E_UNTERM, tok_start, p);
            else if (c == "\\") lex_mode = M_ESC;
            else if (c == "\"") begin
               push_token(K_STR, tok_start, p + 1, '0, E_NONE);
               lex_mode = M_IDLE;
            end
         M_ESC:
            if (c == 0) raise_error(E_UNTERM, tok_start, p);
            else if (c == "\\" || c == "\"" || c == "n" || c == 13 || c == 10) lex_mode = M_STR;
            else raise_error(E_ESCAPE, tok_start, p);
         M_WORD:
            if (letter_char(c) || digit_char(c)) begin
               word_push(c);
            end else begin
               push_token(word_token_kind(), tok_start, p, '0, E_NONE);
               lex_mode = M_IDLE;
               hold = scan_fresh(c, p);
            end
         M_EQ:    hold = scan_pair(c, p, "=", K_EQU, K_SET);
         M_SLASH: hold = scan_pair(c, p, "/", K_FDIV, K_DIV);
         M_GT:    hold = scan_pair(c, p, "=", K_GEQ, K_GTR);
         M_LT:    hold = scan_pair(c, p, "=", K_LEQ, K_LSS);
         M_BANG:
            if (c == "=") begin
               push_token(K_NEQ, tok_start, p + 1, '0, E_NONE);
               lex_mode = M_IDLE;
            end else begin
               raise_error(E_UNKNOWN, tok_start, tok_start);
            end
         M_NEWRUN:
            if (!blank_char(c)) begin
               push_token(K_NEW, tok_start, p, '0, E_NONE);
               lex_mode = M_IDLE;
               hold = scan_fresh(c, p);
            end
         default: begin
            lex_mode = M_IDLE;
            hold = scan_fresh(c, p);
         end
      endcase
      if (!hold) lex_pos = p + 1;
      if (step_tokens > 0) token_q[token_q.size() - 1].last = 1'b1;
   endfunction

   task automatic send_char(logic [20:0] c);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (!req_ready);
      lex_char(c);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char({13'd0, s[i]});
   endtask

   function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               $error("unexpected word: kind %0d start %0d", rsp_token_kind, rsp_token_start);
               fail_count++;
            end else begin
               tok_type t;
               t = token_q.pop_front();
               check_field("token_kind", t.kind, rsp_token_kind);
               check_field("token_start", t.start, rsp_token_start);
               check_field("token_end", t.stop, rsp_token_end);
               check_field("int_value", t.value, rsp_int_value);
               check_field("error_code", t.err, rsp_error_code);
               check_field("last_of_run", t.last, rsp_last_of_run);
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("script_token_lexer_core: mismatch");
         $finish;
      end
   end

   task automatic test_keywords_and_ops();
      send_text("if elif else for from to while def return break continue ");
      send_text("iff continues Ab_9 x ");
      send_text("= == / // > >= < <= != ( ) { } [ ] , + - * % ^ =x/1>a<(");
      send_char(0);
   endtask

   task automatic test_numbers_strings_runs();
      send_text("0 9 2147483647 2147483648 99999999999999 12.5 3.0141;\n \t;");
      send_char(13);
      send_text("x \"ab\\\\\\\"\\n\"");
      send_text("\"q\\");
      send_char(13);
      send_text("\\");
      send_char(10);
      send_char(21'h1FFFFF & 21'h10FFFF);
      send_char(21'h0FFFFF);
      send_text("\"7");
      send_char(0);
   endtask

   task automatic send_random_token();
      string ops [14] = '{"=", "==", "/", "//", ">", ">=", "<", "<=", "!=", "(", ")", ",",
                          "+", "^"};
      string seps [6] = '{" ", ";", "\n", "\t", "(", "-"};
      int    n;
      case ($urandom_range(0, 9))
         0, 1: begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(10, 14) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_char(21'("0" + $urandom_range(0, 9)));
            send_text(seps[$urandom_range(0, 5)]);
         end
         2: begin
            send_char(21'("0" + $urandom_range(0, 9)));
            send_char(".");
            repeat ($urandom_range(1, 3)) send_char(21'("0" + $urandom_range(0, 9)));
            send_text(seps[$urandom_range(0, 5)]);
         end
         3, 4: begin
            if ($urandom_range(0, 1)) begin
               send_text(kw_text[$urandom_range(0, 10)]);
               if ($urandom_range(0, 3) == 0) send_char(21'("a" + $urandom_range(0, 25)));
            end else begin
               n = $urandom_range(1, 11);
               send_char(21'("A" + $urandom_range(0, 25)));
               for (int i = 1; i < n; i++) begin
                  case ($urandom_range(0, 3))
                     0: send_char(21'("0" + $urandom_range(0, 9)));
                     1: send_char("_");
                     2: send_char(21'("A" + $urandom_range(0, 25)));
                     default: send_char(21'("a" + $urandom_range(0, 25)));
                  endcase
               end
            end
            send_text(seps[$urandom_range(0, 5)]);
         end
         5: begin
            send_char("\"");
            repeat ($urandom_range(0, 6)) begin
               case ($urandom_range(0, 4))
                  0: begin
                     send_char("\\");
                     case ($urandom_range(0, 4))
                        0: send_char("\\");
                        1: send_char("\"");
                        2: send_char("n");
                        3: send_char(13);
                        default: send_char(10);
                     endcase
                  end
                  1: send_char(21'($urandom_range(21'h10000, 21'h10FFFF)));
                  default: send_char(21'($urandom_range(32, 126) == 34 ? 39 :
                                         $urandom_range(35, 91)));
               endcase
            end
            send_char("\"");
         end
         6, 7: send_text(ops[$urandom_range(0, 13)]);
         8: repeat ($urandom_range(1, 4)) send_text(seps[$urandom_range(0, 3)]);
         default: if ($urandom_range(0, 3) == 0) send_char(0); else send_char(" ");
      endcase
   endtask

   task automatic test_random_text();
      idle_on = 1'b1;
      stall_on = 1'b1;
      for (int i = 0; i < RANDOM_TOKENS; i++) begin
         if (i % 100 == 0) begin
            idle_on = ($urandom_range(0, 2) != 0);
            stall_on = ($urandom_range(0, 2) != 0);
         end
         send_random_token();
      end
      send_char(0);
   endtask

   task automatic test_error_halt();
      idle_on = 1'b0;
      stall_on = 1'b0;
      send_text("a 1 ");
      case ($urandom_range(0, 5))
         0: send_char(21'h10FFFF);
         1: send_text("!x");
         2: send_text("5.x");
         3: begin send_text("\"abc"); send_char(0); end
         4: begin send_text("\"a\\"); send_char(0); end
         default: send_text("\"a\\q");
      endcase
      send_text("1 + x\"");
      send_char(0);
      req_valid <= 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_code <= '0;
      lex_mode = M_IDLE;
      lex_pos = '0;
      tok_start = '0;
      int_acc = '0;
      word_len = 0;
      lex_halted = 1'b0;
      idle_on = 1'b0;
      stall_on = 1'b0;
      fail_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_keywords_and_ops();
      test_numbers_strings_runs();
      test_random_text();
      test_error_halt();
      while (token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && token_q.size() == 0)
         $display("script_token_lexer_core: match");
      else
         $display("script_token_lexer_core: mismatch");
      $finish;
   end
endmodule

/* filelist.f */
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_back.sv
rtl/script_token_lexer_core.sv
tb/sv/script_token_lexer_core_tb.sv
